### hdl/ctc_greedy_decoder_core_assert.svh
// Assertion macros shared by the CTC greedy decoder RTL files.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef CTC_GREEDY_DECODER_CORE_ASSERT_SVH
`define CTC_GREEDY_DECODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Property checked on every rising clock edge outside of reset.
`define CTCGD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked on every rising clock edge, also during reset.
`define CTCGD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CTCGD_ASSERT(lbl, clk, rst_n, prop, msg)
`define CTCGD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### hdl/ctcgd_pkg.sv
// Types and constants of the CTC greedy decoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package ctcgd_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned CFG_INDEX_W  = 2;
  localparam int unsigned CFG_COUNT_W  = 14;
  localparam int unsigned THRESHOLD_W  = 16;

  // Depth of the step record queue between front and back.
  localparam int unsigned REC_FIFO_DEPTH = 4;

  // Register reset values.
  localparam logic [CFG_COUNT_W-1:0] NUM_CLASSES_RST     = 14'd2;
  localparam logic [CFG_COUNT_W-1:0] DICTIONARY_SIZE_RST = 14'd2;
  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST       = 16'd2458;

  // Register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NUM_CLASSES     = 2'd0,
    REG_DICTIONARY_SIZE = 2'd1,
    REG_MIN_SCORE       = 2'd2
  } cfg_reg_e;

  // Current configuration as seen by front and back.
  typedef struct packed {
    logic        [CFG_COUNT_W-1:0] num_classes;
    logic        [CFG_COUNT_W-1:0] dictionary_size;
    logic signed [THRESHOLD_W-1:0] min_score;
  } cfg_t;

endpackage
`default_nettype wire

### hdl/ctcgd_front.sv
// Front end: accepts class scores, tracks each step's argmax, and emits one
// step record at the last score of every step. Depends on ctcgd_pkg.
`default_nettype none
module ctcgd_front import ctcgd_pkg::*; #(
  parameter int unsigned MAX_CLASSES = 8192,
  parameter int unsigned SCORE_WIDTH = 16,
  parameter int unsigned IDX_W       = 13
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  cfg_t                         cfg_i,
  input  wire logic signed [SCORE_WIDTH-1:0] score_i,
  input  wire                          last_step_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire                          rec_full_i,
  output logic                         rec_push_o,
  output logic        [IDX_W-1:0]      rec_index_o,
  output logic signed [SCORE_WIDTH-1:0] rec_score_o,
  output logic                         rec_final_o
);

  localparam int unsigned CNT_W = $clog2(MAX_CLASSES + 1);
  localparam int unsigned CMP_W = ((CNT_W > CFG_COUNT_W) ? CNT_W : CFG_COUNT_W) + 1;

  logic        [IDX_W-1:0]       counter_q, counter_d;
  logic signed [SCORE_WIDTH-1:0] best_score_q, best_score_d;
  logic        [IDX_W-1:0]       best_index_q, best_index_d;
  logic        [CMP_W-1:0]       n_raw, n_eff, pos_next;
  logic                          take, end_of_step, accept;

  // Clamp the class count to the range one to MAX_CLASSES.
  always_comb begin
    n_raw = CMP_W'(cfg_i.num_classes);
    if (n_raw == '0) begin
      n_eff = CMP_W'(1);
    end else if (n_raw > CMP_W'(MAX_CLASSES)) begin
      n_eff = CMP_W'(MAX_CLASSES);
    end else begin
      n_eff = n_raw;
    end
  end

  assign pos_next    = CMP_W'(counter_q) + CMP_W'(1);
  assign end_of_step = (pos_next >= n_eff);
  assign in_ready_o  = !rec_full_i;
  assign accept      = in_valid_i && in_ready_o;

  // Running argmax; a strictly greater score replaces, so the first tie wins.
  assign take = (counter_q == '0) || (score_i > best_score_q);

  always_comb begin
    counter_d    = counter_q;
    best_score_d = best_score_q;
    best_index_d = best_index_q;
    if (accept) begin
      if (take) begin
        best_score_d = score_i;
        best_index_d = counter_q;
      end
      counter_d = end_of_step ? '0 : counter_q + IDX_W'(1);
    end
  end

  // The step record carries the argmax including the current score.
  assign rec_push_o  = accept && end_of_step;
  assign rec_index_o = best_index_d;
  assign rec_score_o = best_score_d;
  assign rec_final_o = last_step_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counter_q    <= '0;
      best_score_q <= '0;
      best_index_q <= '0;
    end else begin
      counter_q    <= counter_d;
      best_score_q <= best_score_d;
      best_index_q <= best_index_d;
    end
  end

endmodule
`default_nettype wire

### hdl/ctcgd_fifo.sv
// Short register queue that decouples the argmax front from the back end.
// Depends on ctcgd_pkg and the assertion macro header.
`default_nettype none
`include "ctc_greedy_decoder_core_assert.svh"
module ctcgd_fifo import ctcgd_pkg::*; #(
  parameter int unsigned WIDTH = 30,
  parameter int unsigned DEPTH = 4
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire [WIDTH-1:0]  wdata_i,
  output logic             full_o,
  input  wire              pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  `CTCGD_ASSERT(a_no_push_full, clk_i, rst_ni, push_i |-> !full_o, "push into full queue")
  `CTCGD_ASSERT(a_no_pop_empty, clk_i, rst_ni, pop_i |-> valid_o, "pop from empty queue")
  `CTCGD_ASSERT_ALWAYS(a_count_range, clk_i, count_q <= CNT_W'(DEPTH), "fill count out of range")

endmodule
`default_nettype wire

### hdl/ctcgd_back.sv
// Back end: turns step records into character and verdict results, keeps
// the per-sequence state and the output register. Depends on ctcgd_pkg.
`default_nettype none
`include "ctc_greedy_decoder_core_assert.svh"
module ctcgd_back import ctcgd_pkg::*; #(
  parameter int unsigned SCORE_WIDTH = 16,
  parameter int unsigned IDX_W       = 13
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  cfg_t                         cfg_i,
  input  wire                          rec_valid_i,
  input  wire        [IDX_W-1:0]       rec_index_i,
  input  wire logic signed [SCORE_WIDTH-1:0] rec_score_i,
  input  wire                          rec_final_i,
  output logic                         rec_pop_o,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic        [IDX_W-1:0]      char_index_o,
  output logic                         is_verdict_o,
  output logic                         accepted_o,
  output logic                         last_o
);

  localparam int unsigned CMP_W = ((IDX_W > CFG_COUNT_W) ? IDX_W : CFG_COUNT_W) + 1;
  localparam int unsigned TH_W  = ((SCORE_WIDTH > THRESHOLD_W) ? SCORE_WIDTH : THRESHOLD_W) + 1;
  localparam logic signed [SCORE_WIDTH-1:0] SCORE_MIN = {1'b1, {(SCORE_WIDTH - 1){1'b0}}};

  // Sequence state.
  logic        [IDX_W-1:0]       prev_q, prev_d;
  logic                          any_q, any_d;
  logic signed [SCORE_WIDTH-1:0] best_q, best_d;
  // A verdict that waits behind a character result.
  logic                          pend_q, pend_d;
  logic                          pend_acc_q, pend_acc_d;
  // Output register.
  logic                          out_valid_q, out_valid_d;
  logic        [IDX_W-1:0]       out_char_q, out_char_d;
  logic                          out_verdict_q, out_verdict_d;
  logic                          out_acc_q, out_acc_d;

  logic                          slot_free, pop, emit, any_upd, ok;
  logic signed [SCORE_WIDTH-1:0] best_upd;

  assign slot_free = !out_valid_q || out_ready_i;
  assign pop       = rec_valid_i && slot_free && !pend_q;
  assign rec_pop_o = pop;

  // Emission rule and the verdict that follows on the final step.
  assign emit = (rec_index_i != '0) &&
                (CMP_W'(rec_index_i) < CMP_W'(cfg_i.dictionary_size)) &&
                (rec_index_i != prev_q);
  assign best_upd = (emit && (rec_score_i > best_q)) ? rec_score_i : best_q;
  assign any_upd  = any_q || emit;
  assign ok       = any_upd &&
                    (TH_W'(best_upd) >= TH_W'(cfg_i.min_score));

  // Sequence state update.
  always_comb begin
    prev_d = prev_q;
    any_d  = any_q;
    best_d = best_q;
    if (pop) begin
      if (rec_final_i) begin
        prev_d = '0;
        any_d  = 1'b0;
        best_d = SCORE_MIN;
      end else begin
        prev_d = rec_index_i;
        any_d  = any_upd;
        best_d = best_upd;
      end
    end
  end

  // Output register and pending verdict.
  always_comb begin
    out_valid_d   = out_valid_q;
    out_char_d    = out_char_q;
    out_verdict_d = out_verdict_q;
    out_acc_d     = out_acc_q;
    pend_d        = pend_q;
    pend_acc_d    = pend_acc_q;
    if (slot_free) begin
      out_valid_d = 1'b0;
      if (pend_q) begin
        out_valid_d   = 1'b1;
        out_char_d    = '0;
        out_verdict_d = 1'b1;
        out_acc_d     = pend_acc_q;
        pend_d        = 1'b0;
      end else if (pop && emit) begin
        out_valid_d   = 1'b1;
        out_char_d    = rec_index_i;
        out_verdict_d = 1'b0;
        out_acc_d     = 1'b0;
        pend_d        = rec_final_i;
        pend_acc_d    = ok;
      end else if (pop && rec_final_i) begin
        out_valid_d   = 1'b1;
        out_char_d    = '0;
        out_verdict_d = 1'b1;
        out_acc_d     = ok;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      any_q       <= 1'b0;
      best_q      <= SCORE_MIN;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      prev_q      <= prev_d;
      any_q       <= any_d;
      best_q      <= best_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    pend_acc_q    <= pend_acc_d;
    out_char_q    <= out_char_d;
    out_verdict_q <= out_verdict_d;
    out_acc_q     <= out_acc_d;
  end

  assign out_valid_o  = out_valid_q;
  assign char_index_o = out_char_q;
  assign is_verdict_o = out_verdict_q;
  assign accepted_o   = out_acc_q;
  assign last_o       = out_verdict_q;

  `CTCGD_ASSERT(a_pend_behind_char, clk_i, rst_ni,
                pend_q |-> (out_valid_q && !out_verdict_q), "pending verdict without character")
  `CTCGD_ASSERT(a_new_sequence, clk_i, rst_ni,
                (pop && rec_final_i) |=> (!any_q && prev_q == '0), "sequence not restarted")
  `CTCGD_ASSERT(a_verdict_char_zero, clk_i, rst_ni,
                (out_valid_q && out_verdict_q) |-> (out_char_q == '0), "verdict carries an index")

endmodule
`default_nettype wire

### hdl/ctc_greedy_decoder_core.sv
// CTC greedy decoder top level; instantiates ctcgd_front, ctcgd_fifo and ctcgd_back.
// Results pass through the step record queue and then the output register; a verdict that
// follows a character waits in a pending register until the character has been taken.
// Throughput: one score per cycle and at most one result per cycle; the input stalls only
// when the four-record queue is full, which happens only while the output is held off.
// Reset: asynchronous, active low; clears all control state and loads the register defaults.
`default_nettype none
module ctc_greedy_decoder_core import ctcgd_pkg::*; #(
  parameter int unsigned MAX_CLASSES = 8192,
  parameter int unsigned SCORE_WIDTH = 16
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire        [CFG_INDEX_W-1:0]       cfg_index_i,
  input  wire        [CFG_DATA_W-1:0]        cfg_wdata_i,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [SCORE_WIDTH-1:0] score_i,
  input  wire                                last_step_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic       [$clog2(MAX_CLASSES)-1:0] char_index_o,
  output logic                               is_verdict_o,
  output logic                               accepted_o,
  output logic                               last_o
);

  localparam int unsigned IDX_W = $clog2(MAX_CLASSES);
  localparam int unsigned REC_W = IDX_W + SCORE_WIDTH + 1;

  cfg_t cfg_q, cfg_d;

  // Configuration writes; indexes beyond the list are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_NUM_CLASSES:     cfg_d.num_classes = cfg_wdata_i[CFG_COUNT_W-1:0];
        REG_DICTIONARY_SIZE: cfg_d.dictionary_size = cfg_wdata_i[CFG_COUNT_W-1:0];
        REG_MIN_SCORE:       cfg_d.min_score = cfg_wdata_i[THRESHOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_classes     <= NUM_CLASSES_RST;
      cfg_q.dictionary_size <= DICTIONARY_SIZE_RST;
      cfg_q.min_score       <= THRESHOLD_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  logic                          rec_full, rec_push, rec_final, rec_pop, rec_valid;
  logic        [IDX_W-1:0]       rec_index;
  logic signed [SCORE_WIDTH-1:0] rec_score;
  logic        [REC_W-1:0]       rec_rdata;

  // Argmax front.
  ctcgd_front #(
    .MAX_CLASSES (MAX_CLASSES),
    .SCORE_WIDTH (SCORE_WIDTH),
    .IDX_W       (IDX_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .score_i     (score_i),
    .last_step_i (last_step_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rec_full_i  (rec_full),
    .rec_push_o  (rec_push),
    .rec_index_o (rec_index),
    .rec_score_o (rec_score),
    .rec_final_o (rec_final)
  );

  // Step record queue.
  ctcgd_fifo #(
    .WIDTH (REC_W),
    .DEPTH (REC_FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .wdata_i ({rec_final, rec_score, rec_index}),
    .full_o  (rec_full),
    .pop_i   (rec_pop),
    .valid_o (rec_valid),
    .rdata_o (rec_rdata)
  );

  // Result generation.
  ctcgd_back #(
    .SCORE_WIDTH (SCORE_WIDTH),
    .IDX_W       (IDX_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .rec_valid_i  (rec_valid),
    .rec_index_i  (rec_rdata[IDX_W-1:0]),
    .rec_score_i  (rec_rdata[IDX_W +: SCORE_WIDTH]),
    .rec_final_i  (rec_rdata[REC_W-1]),
    .rec_pop_o    (rec_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .char_index_o (char_index_o),
    .is_verdict_o (is_verdict_o),
    .accepted_o   (accepted_o),
    .last_o       (last_o)
  );

endmodule
`default_nettype wire

### test/tb_top.sv
// Self-checking testbench of the CTC greedy decoder core: a directed table, then random phases.
// Depends on ctcgd_pkg and ctc_greedy_decoder_core; results are predicted by an in-bench decoder.
module tb_top;
  import ctcgd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_CLASSES  = 8192;
  localparam int unsigned SCORE_WIDTH  = 16;
  localparam int unsigned CHAR_W       = $clog2(MAX_CLASSES);
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LONG_HOLD    = 150;
  localparam int unsigned RUN_LIMIT_NS = 4_000_000;

  // Index that maps to no register; writes to it must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic signed [SCORE_WIDTH-1:0] SCORE_MIN = {1'b1, {(SCORE_WIDTH-1){1'b0}}};
  localparam logic signed [SCORE_WIDTH-1:0] SCORE_MAX = {1'b0, {(SCORE_WIDTH-1){1'b1}}};

  typedef struct packed {
    logic [CHAR_W-1:0] char_index;
    logic              is_verdict;
    logic              accepted;
    logic              last;
  } dec_result_t;

  // One row of the directed table: a register write or a score, with an optional
  // hand-written expectation.
  typedef struct packed {
    logic                   is_cfg;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0]  reg_data;
    logic [SCORE_WIDTH-1:0] score;
    logic                   fin;
    logic                   typed;
    logic [1:0]             n_typed;
    dec_result_t            exp0;
    dec_result_t            exp1;
  } stim_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [CFG_INDEX_W-1:0]        cfg_index_i;
  logic [CFG_DATA_W-1:0]         cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic signed [SCORE_WIDTH-1:0] score_i;
  logic                          last_step_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [CHAR_W-1:0]             char_index_o;
  logic                          is_verdict_o;
  logic                          accepted_o;
  logic                          last_o;

  ctc_greedy_decoder_core #(
    .MAX_CLASSES(MAX_CLASSES),
    .SCORE_WIDTH(SCORE_WIDTH)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .score_i     (score_i),
    .last_step_i (last_step_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .char_index_o(char_index_o),
    .is_verdict_o(is_verdict_o),
    .accepted_o  (accepted_o),
    .last_o      (last_o)
  );

  // Predictor state, at its reset values, and its copy of the registers.
  logic [CFG_COUNT_W-1:0]        cls_count_reg;
  logic [CFG_COUNT_W-1:0]        dict_size_reg;
  logic signed [THRESHOLD_W-1:0] thr_reg;
  int unsigned                   step_pos = 0;
  logic signed [SCORE_WIDTH-1:0] step_max = '0;
  int unsigned                   step_arg = 0;
  int unsigned                   prev_char = 0;
  bit                            seq_has_char = 1'b0;
  logic signed [SCORE_WIDTH-1:0] seq_best = SCORE_MIN;

  dec_result_t expected_results[$];
  stim_row_t   cur_row;
  int unsigned mismatches = 0;
  int unsigned hold_requests;
  int unsigned hold_served = 0;
  bit          sender_gaps_on;

  // Effective step length: zero acts as one, the count saturates at MAX_CLASSES.
  function automatic int unsigned classes_in_step(logic [CFG_COUNT_W-1:0] nc);
    int unsigned n;
    n = nc;
    if (n < 1) n = 1;
    if (n > MAX_CLASSES) n = MAX_CLASSES;
    return n;
  endfunction

  function automatic dec_result_t char_res(int unsigned idx);
    dec_result_t r;
    r = '0;
    r.char_index = CHAR_W'(idx);
    return r;
  endfunction

  function automatic dec_result_t verdict_res(bit acc);
    dec_result_t r;
    r = '0;
    r.is_verdict = 1'b1;
    r.accepted = acc;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t row_cfg(logic [CFG_INDEX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_idx = idx;
    r.reg_data = data;
    return r;
  endfunction

  function automatic stim_row_t row_item(logic signed [SCORE_WIDTH-1:0] sc, logic fin);
    stim_row_t r;
    r = '0;
    r.score = sc;
    r.fin = fin;
    return r;
  endfunction

  function automatic stim_row_t row_typed(logic signed [SCORE_WIDTH-1:0] sc, logic fin,
                                          int unsigned n, dec_result_t e0, dec_result_t e1);
    stim_row_t r;
    r = row_item(sc, fin);
    r.typed = 1'b1;
    r.n_typed = 2'(n);
    r.exp0 = e0;
    r.exp1 = e1;
    return r;
  endfunction

  // Running argmax over one step; at the step end the character and verdict results
  // are worked out and, when record is set, queued as expectations.
  function automatic void decode_score(logic signed [SCORE_WIDTH-1:0] sc, logic fin,
                                       bit record);
    int unsigned n;
    bit          ok;
    n = classes_in_step(cls_count_reg);
    if (step_pos == 0 || sc > step_max) begin
      step_max = sc;
      step_arg = step_pos;
    end
    if (step_pos + 1 < n) begin
      step_pos++;
    end else begin
      step_pos = 0;
      if (step_arg != 0 && step_arg < dict_size_reg && step_arg != prev_char) begin
        if (record) expected_results.push_back(char_res(step_arg));
        seq_has_char = 1'b1;
        if (step_max > seq_best) seq_best = step_max;
      end
      prev_char = step_arg;
      if (fin) begin
        ok = seq_has_char && (seq_best >= thr_reg);
        if (record) expected_results.push_back(verdict_res(ok));
        prev_char = 0;
        seq_has_char = 1'b0;
        seq_best = SCORE_MIN;
      end
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Scores: many small values to force ties, some full range, extremes and values
  // near the threshold.
  function automatic logic signed [SCORE_WIDTH-1:0] gen_score();
    int v;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) v = int'($urandom_range(0, 16)) - 8;
    else if (r < 65) v = int'($urandom_range(0, 65535)) - 32768;
    else if (r < 80) v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
    else v = thr_reg + int'($urandom_range(0, 8)) - 4;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return SCORE_WIDTH'(v);
  endfunction

  // Gap before an item: mostly none, some short, a few long.
  function automatic int unsigned idle_gap();
    int unsigned r;
    if (!sender_gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  task automatic send_item(stim_row_t row);
    int unsigned gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cur_row = row;
    score_i = row.score;
    last_step_i = row.fin;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Lower valid, let every expected result arrive, then let the pipeline settle.
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index_i = idx;
    cfg_wdata_i = data;
    cfg_we_i = 1'b1;
    case (idx)
      REG_NUM_CLASSES:     cls_count_reg = data[CFG_COUNT_W-1:0];
      REG_DICTIONARY_SIZE: dict_size_reg = data[CFG_COUNT_W-1:0];
      REG_MIN_SCORE:       thr_reg = data[THRESHOLD_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("Mismatches found");
    $finish;
  end

  // Result side: per-cycle ready with random stalls, calm stretches, and a long
  // hold-off on request from the stimulus.
  initial begin : result_sink
    int unsigned stall_left;
    bit          calm;
    out_ready_i = 1'b0;
    stall_left = 0;
    calm = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_requests) begin
        out_ready_i = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
        hold_served = hold_requests;
      end else if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) begin
          stall_left = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 3)
                                                   : $urandom_range(8, 40);
        end
        if ($urandom_range(0, 199) == 0) calm = !calm;
      end
    end
  end

  // Prediction on each input transfer, then comparison on each output transfer.
  always @(posedge clk_i) begin : scoreboard
    dec_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        decode_score(score_i, last_step_i, !cur_row.typed);
        if (cur_row.typed && cur_row.n_typed > 0) expected_results.push_back(cur_row.exp0);
        if (cur_row.typed && cur_row.n_typed > 1) expected_results.push_back(cur_row.exp1);
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: expected no result, got index %0d verdict %0b accepted %0b last %0b",
                   $time, char_index_o, is_verdict_o, accepted_o, last_o);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("char_index", want.char_index, char_index_o);
          check_field("is_verdict", want.is_verdict, is_verdict_o);
          check_field("accepted", want.accepted, accepted_o);
          check_field("last", want.last, last_o);
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t                     directed_rows[$];
    dec_result_t                   none;
    int unsigned                   eff, steps, plant, sent, budget, last_phase;
    logic [CFG_COUNT_W-1:0]        nc, dict;
    logic [THRESHOLD_W-1:0]        thr;
    logic signed [SCORE_WIDTH-1:0] sc;
    logic                          fin;

    // Every input known from time zero; register copy at its reset state.
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_NUM_CLASSES;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    score_i = '0;
    last_step_i = 1'b0;
    cur_row = '0;
    hold_requests = 0;
    sender_gaps_on = 1'b1;
    cls_count_reg = NUM_CLASSES_RST;
    dict_size_reg = DICTIONARY_SIZE_RST;
    thr_reg = THRESHOLD_RST;
    none = '0;
    last_phase = NUM_PHASES - 1;

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed table, starting from the reset configuration of two classes.
    directed_rows.push_back(row_typed(16'sd100, 1'b0, 0, none, none));
    directed_rows.push_back(row_typed(16'sd4096, 1'b1, 2, char_res(1), verdict_res(1'b1)));
    // The final-step marker on a score that does not end its step is ignored.
    directed_rows.push_back(row_typed(16'sd500, 1'b1, 0, none, none));
    // Tied maxima pick the blank; nothing emitted, so the verdict rejects.
    directed_rows.push_back(row_typed(16'sd500, 1'b1, 1, verdict_res(1'b0), none));
    directed_rows.push_back(row_item(SCORE_MIN, 1'b0));
    directed_rows.push_back(row_typed(SCORE_MAX, 1'b0, 1, char_res(1), none));
    directed_rows.push_back(row_item(16'sd0, 1'b0));
    directed_rows.push_back(row_typed(-16'sd1, 1'b0, 0, none, none));
    // Same class again after a blank step, then a plain repeat.
    directed_rows.push_back(row_item(-16'sd5, 1'b0));
    directed_rows.push_back(row_item(16'sd7, 1'b0));
    directed_rows.push_back(row_item(16'sd0, 1'b0));
    directed_rows.push_back(row_item(16'sd9, 1'b1));
    directed_rows.push_back(row_cfg(REG_MIN_SCORE, 16'h7FFF));
    directed_rows.push_back(row_item(16'sd0, 1'b0));
    directed_rows.push_back(row_typed(SCORE_MAX, 1'b1, 2, char_res(1), verdict_res(1'b1)));
    directed_rows.push_back(row_cfg(REG_MIN_SCORE, 16'h8000));
    directed_rows.push_back(row_cfg(REG_DICTIONARY_SIZE, 16'h0000));
    directed_rows.push_back(row_item(16'sd0, 1'b0));
    directed_rows.push_back(row_typed(16'sd100, 1'b1, 1, verdict_res(1'b0), none));
    // Upper data bits beyond the register width are dropped: three classes.
    directed_rows.push_back(row_cfg(REG_DICTIONARY_SIZE, 16'h3FFF));
    directed_rows.push_back(row_cfg(REG_NUM_CLASSES, 16'hC003));
    directed_rows.push_back(row_item(SCORE_MIN, 1'b0));
    directed_rows.push_back(row_item(SCORE_MIN, 1'b0));
    directed_rows.push_back(row_typed(SCORE_MIN, 1'b1, 1, verdict_res(1'b0), none));
    directed_rows.push_back(row_item(16'sd1, 1'b0));
    directed_rows.push_back(row_item(16'sd2, 1'b0));
    directed_rows.push_back(row_item(16'sd2, 1'b1));
    // A class count of zero makes every score a step of its own.
    directed_rows.push_back(row_cfg(REG_NUM_CLASSES, 16'd0));
    directed_rows.push_back(row_typed(SCORE_MAX, 1'b1, 1, verdict_res(1'b0), none));
    // Class count lowered in the middle of a step ends it at the next score.
    directed_rows.push_back(row_cfg(REG_NUM_CLASSES, 16'd4));
    directed_rows.push_back(row_item(16'sd10, 1'b0));
    directed_rows.push_back(row_item(16'sd20, 1'b0));
    directed_rows.push_back(row_cfg(REG_NUM_CLASSES, 16'd2));
    directed_rows.push_back(row_item(16'sd5, 1'b0));
    directed_rows.push_back(row_cfg(REG_UNUSED, 16'hFFFF));

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        wait_idle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
      end else begin
        send_item(directed_rows[i]);
      end
    end

    // Random phases. The first backs up the output with a long hold-off; the last
    // runs long steps with the peak of the final step on its last class.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 0) begin
        nc = 14'd2;
        dict = 14'h3FFF;
        thr = 16'($urandom_range(0, 65535));
      end else if (p == last_phase) begin
        nc = 14'd32;
        dict = 14'h3FFF;
        thr = 16'($urandom_range(0, 65535));
      end else begin
        case ($urandom_range(0, 5))
          0:       nc = 14'd0;
          1:       nc = 14'd1;
          default: nc = 14'($urandom_range(2, 12));
        endcase
        case ($urandom_range(0, 5))
          0:       dict = 14'd0;
          1:       dict = 14'd1;
          2:       dict = nc;
          3:       dict = 14'($urandom_range(0, nc + 2));
          4:       dict = 14'h3FFF;
          default: dict = 14'($urandom_range(0, 16383));
        endcase
        case ($urandom_range(0, 4))
          0:       thr = 16'h8000;
          1:       thr = 16'h7FFF;
          2:       thr = 16'($urandom_range(0, 65535));
          default: thr = 16'(int'($urandom_range(0, 8000)) - 2000);
        endcase
      end

      wait_idle();
      write_reg(REG_NUM_CLASSES, {2'($urandom_range(0, 3)), nc});
      write_reg(REG_DICTIONARY_SIZE, {2'($urandom_range(0, 3)), dict});
      write_reg(REG_MIN_SCORE, thr);

      eff = classes_in_step(nc);
      sender_gaps_on = (p % 3 != 1) && (p != 0) && (p != last_phase);
      if (p == 0) hold_requests++;
      budget = (p == 0) ? 200 : ((p == last_phase) ? 2 * eff : 90);
      sent = 0;

      // Well-formed sequences of whole steps; the final-step marker is set at random
      // on inner scores, where it must be ignored, and is sometimes left off.
      while (sent < budget) begin
        steps = (p == last_phase) ? 2 : $urandom_range(1, 8);
        for (int s = 0; s < steps; s++) begin
          plant = eff;
          if (p == last_phase) plant = (s == steps - 1) ? eff - 1 : $urandom_range(0, eff - 1);
          for (int c = 0; c < eff; c++) begin
            if (c == plant) sc = SCORE_MAX;
            else if (p == last_phase) sc = SCORE_WIDTH'(int'($urandom_range(0, 2000)) - 1000);
            else sc = gen_score();
            if (c == eff - 1) fin = (s == steps - 1) && ($urandom_range(0, 7) != 0);
            else fin = 1'($urandom_range(0, 1));
            send_item(row_item(sc, fin));
            sent++;
          end
        end
      end
    end

    wait_idle();
    repeat (20) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
